/* design/lfhs_pkg.sv */
// shared types and constants for the lattice fermion hop and sign tracker
package lfhs_pkg;

    // fixed field widths
    localparam int MODE_W = 2;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 7;
    localparam int CNT_W  = 7;
    localparam int OCC_W  = 2;
    localparam int ERR_W  = 2;

    // largest lattice and particle count that a 6 bit index reaches
    localparam int ADDR_SPAN = 64;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_HOP_UP      = 2'd0,
        MODE_HOP_DOWN    = 2'd1,
        MODE_CREATE_UP   = 2'd2,
        MODE_CREATE_DOWN = 2'd3
    } mode_t;

    // error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_PARTICLE = 2'd1,
        ERR_LIMIT    = 2'd2
    } err_t;

    // configuration register indexes
    localparam logic CFG_UP_LIMIT   = 1'b0;
    localparam logic CFG_DOWN_LIMIT = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // input transaction payload
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  particle;
        logic [IDX_W-1:0]  site;
    } in_item_t;

    // output transaction payload
    typedef struct packed {
        logic              step_parity;
        logic              sign_negative;
        logic [OCC_W-1:0]  dest_occupancy;
        logic [ERR_W-1:0]  error;
    } out_item_t;

    // command to the serial parity unit: parity of the set bits with lo <= index < hi
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
    } scan_cmd_t;

    // status back from the serial parity unit
    typedef struct packed {
        logic done;
        logic parity;
    } scan_res_t;

endpackage

/* design/lfhs_ram.sv */
// generic single write port, single read port ram with registered read
module lfhs_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/lfhs_scan.sv */
// bit-serial range parity over one or two occupancy bitmaps
module lfhs_scan import lfhs_pkg::*; #(
    parameter int SITE_CNT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scan_cmd_t           cmd,
    input  logic [SITE_CNT-1:0] map_a,
    input  logic [SITE_CNT-1:0] map_b,
    output scan_res_t           res
);

    logic [SITE_CNT-1:0] sr_a_reg;
    logic [SITE_CNT-1:0] sr_b_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic                parity_reg;
    logic                busy_reg;
    logic                at_end;
    logic                in_win;
    logic                bit_now;

    assign at_end  = (idx_reg == hi_reg);
    assign in_win  = (idx_reg >= lo_reg);
    assign bit_now = sr_a_reg[0] ^ sr_b_reg[0];

    // counter and parity accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            parity_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            busy_reg   <= 1'b1;
            idx_reg    <= '0;
            parity_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (at_end)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg    <= idx_reg + CNT_W'(1);
                parity_reg <= parity_reg ^ (bit_now & in_win);
            end
        end
    end

    // shift registers, one site per cycle while a scan runs
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sr_a_reg <= map_a;
            sr_b_reg <= map_b;
            lo_reg   <= cmd.lo;
            hi_reg   <= cmd.hi;
        end
        else if (busy_reg && !at_end)
        begin
            sr_a_reg <= sr_a_reg >> 1;
            sr_b_reg <= sr_b_reg >> 1;
        end
    end

    assign res.done   = busy_reg && at_end;
    assign res.parity = parity_reg;

endmodule

/* design/lattice_fermion_hop_sign.sv */
// Flow: an accepted item is held through lookup and, when it moves or creates a particle,
// through a bit-serial parity scan up to hi, the larger of source and destination site for
// a hop and the destination site for a creation, then the update; an item that changes
// nothing skips scan and update. The block takes no new item until the result of the last
// is loaded into the output register; the scan walks the occupancy bitmaps one site per cycle.
// Reset: lattice empty, sign plus one, created counts and limits zero; no clearing pass.
module lattice_fermion_hop_sign import lfhs_pkg::*; #(
    parameter int SITES         = 64,
    parameter int MAX_PARTICLES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // sizes reachable through the 6 bit indexes
    localparam int SITE_CNT = (SITES < ADDR_SPAN) ? SITES : ADDR_SPAN;
    localparam int SW       = $clog2(SITE_CNT);
    localparam int PART_CNT = (MAX_PARTICLES < ADDR_SPAN) ? MAX_PARTICLES : ADDR_SPAN;
    localparam int PW       = (PART_CNT > 1) ? $clog2(PART_CNT) : 1;
    localparam int RAM_AW   = PW + 1;
    localparam int RAM_D    = 2 ** RAM_AW;
    localparam int LIM_CAP  = (MAX_PARTICLES < 127) ? MAX_PARTICLES : 127;
    localparam logic [CNT_W-1:0] SITE_LIM = CNT_W'(SITE_CNT);
    localparam logic [CNT_W-1:0] PART_LIM = CNT_W'(PART_CNT);
    localparam logic [CNT_W-1:0] LIM_MAX  = CNT_W'(LIM_CAP);

    state_t              state_reg;
    state_t              state_next;
    in_item_t            item_reg;
    logic [SW-1:0]       from_reg;
    logic                parity_reg;
    logic [ERR_W-1:0]    err_reg;
    logic                sign_reg;
    logic [CNT_W-1:0]    created_up_reg;
    logic [CNT_W-1:0]    created_dn_reg;
    logic [CFG_W-1:0]    lim_up_reg;
    logic [CFG_W-1:0]    lim_dn_reg;
    logic [SITE_CNT-1:0] occ_up_reg;
    logic [SITE_CNT-1:0] occ_dn_reg;
    logic [SITE_CNT-1:0] occ_up_next;
    logic [SITE_CNT-1:0] occ_dn_next;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                in_accept;
    logic                out_free;
    logic                look_en;
    logic                upd_en;
    logic                out_load;
    logic                ram_we;
    scan_cmd_t           scan_cmd;
    scan_res_t           scan_res;

    logic                is_hop;
    logic                is_up;
    logic                site_ok;
    logic [SW-1:0]       sidx;
    logic [SITE_CNT-1:0] same_occ;
    logic                dest_busy;
    logic [CNT_W-1:0]    created_sel;
    logic [CFG_W-1:0]    lim_raw;
    logic [CNT_W-1:0]    lim_sel;
    logic                err_part;
    logic                err_lim;
    logic [ERR_W-1:0]    err_code;
    logic                change;
    logic [SW-1:0]       from_rd;
    logic [CNT_W-1:0]    from_ext;
    logic [CNT_W-1:0]    site_ext;
    logic [CNT_W-1:0]    lo_cmd;
    logic [CNT_W-1:0]    hi_cmd;
    logic [SITE_CNT-1:0] map_a;
    logic [SITE_CNT-1:0] map_b;
    logic [RAM_AW-1:0]   rd_addr;
    logic [RAM_AW-1:0]   wr_addr;
    logic [OCC_W-1:0]    occ_out;

    // decode of the held transaction
    assign is_hop   = (item_reg.mode == MODE_HOP_UP) || (item_reg.mode == MODE_HOP_DOWN);
    assign is_up    = (item_reg.mode == MODE_HOP_UP) || (item_reg.mode == MODE_CREATE_UP);
    assign site_ext = {1'b0, item_reg.site};
    assign site_ok  = site_ext < SITE_LIM;
    assign sidx     = item_reg.site[SW-1:0];
    assign same_occ = is_up ? occ_up_reg : occ_dn_reg;
    assign dest_busy = site_ok && same_occ[sidx];

    // error checks
    assign created_sel = is_up ? created_up_reg : created_dn_reg;
    assign lim_raw     = is_up ? lim_up_reg : lim_dn_reg;
    assign lim_sel     = (lim_raw > LIM_MAX) ? LIM_MAX : lim_raw;
    assign err_part    = ({1'b0, item_reg.particle} >= created_sel) ||
                         ({1'b0, item_reg.particle} >= PART_LIM);
    assign err_lim     = created_sel >= lim_sel;

    always_comb
    begin
        if (is_hop)
        begin
            err_code = err_part ? ERR_PARTICLE : ERR_NONE;
        end
        else
        begin
            err_code = err_lim ? ERR_LIMIT : ERR_NONE;
        end
    end

    assign change = (err_code == ERR_NONE) && site_ok && !dest_busy;

    // scan window and bitmaps
    assign from_ext = {{(CNT_W-SW){1'b0}}, from_rd};

    always_comb
    begin
        if (is_hop)
        begin
            lo_cmd = ((from_ext < site_ext) ? from_ext : site_ext) + CNT_W'(1);
            hi_cmd = (from_ext < site_ext) ? site_ext : from_ext;
            map_a  = same_occ;
            map_b  = '0;
        end
        else
        begin
            lo_cmd = '0;
            hi_cmd = site_ext;
            map_a  = occ_up_reg;
            map_b  = is_up ? '0 : occ_dn_reg;
        end
    end

    // particle-to-site list, both species in one ram
    assign rd_addr = {(in_data.mode == MODE_HOP_DOWN) || (in_data.mode == MODE_CREATE_DOWN),
                      in_data.particle[PW-1:0]};
    assign wr_addr = {!is_up, is_hop ? item_reg.particle[PW-1:0] : created_sel[PW-1:0]};

    lfhs_ram #(
        .WIDTH (SW),
        .DEPTH (RAM_D)
    ) u_site_list (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (sidx),
        .rd_addr (rd_addr),
        .rd_data (from_rd)
    );

    lfhs_scan #(
        .SITE_CNT (SITE_CNT)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scan_cmd),
        .map_a (map_a),
        .map_b (map_b),
        .res   (scan_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = change ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller outputs
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        in_stall       = 1'b1;
        look_en        = 1'b0;
        upd_en         = 1'b0;
        out_load       = 1'b0;
        scan_cmd.start = 1'b0;
        scan_cmd.lo    = lo_cmd;
        scan_cmd.hi    = hi_cmd;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_LOOKUP:
            begin
                look_en        = 1'b1;
                scan_cmd.start = change;
            end
            ST_SCAN:
            begin
                in_stall = 1'b1;
            end
            ST_UPDATE:
            begin
                upd_en = 1'b1;
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign in_accept = in_valid && !in_stall;
    assign ram_we    = upd_en;

    // occupancy bitmap update
    always_comb
    begin
        occ_up_next = occ_up_reg;
        occ_dn_next = occ_dn_reg;
        if (upd_en)
        begin
            if (is_up)
            begin
                if (is_hop)
                begin
                    occ_up_next[from_reg] = 1'b0;
                end
                occ_up_next[sidx] = 1'b1;
            end
            else
            begin
                if (is_hop)
                begin
                    occ_dn_next[from_reg] = 1'b0;
                end
                occ_dn_next[sidx] = 1'b1;
            end
        end
    end

    // control and lattice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sign_reg       <= 1'b0;
            created_up_reg <= '0;
            created_dn_reg <= '0;
            lim_up_reg     <= '0;
            lim_dn_reg     <= '0;
            occ_up_reg     <= '0;
            occ_dn_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_up_reg <= occ_up_next;
            occ_dn_reg <= occ_dn_next;
            if (upd_en)
            begin
                sign_reg <= sign_reg ^ scan_res.parity;
                if (!is_hop && is_up)
                begin
                    created_up_reg <= created_up_reg + CNT_W'(1);
                end
                if (!is_hop && !is_up)
                begin
                    created_dn_reg <= created_dn_reg + CNT_W'(1);
                end
            end
            if (cfg_write && (cfg_index == CFG_UP_LIMIT))
            begin
                lim_up_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == CFG_DOWN_LIMIT))
            begin
                lim_dn_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // destination occupancy after the step
    assign occ_out = site_ok ? {occ_dn_reg[sidx], occ_up_reg[sidx]} : '0;

    // transaction payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= in_data;
        end
        if (look_en)
        begin
            from_reg   <= from_rd;
            err_reg    <= err_code;
            parity_reg <= 1'b0;
        end
        if (upd_en)
        begin
            parity_reg <= scan_res.parity;
        end
        if (out_load)
        begin
            out_data_reg.step_parity    <= parity_reg;
            out_data_reg.sign_negative  <= sign_reg;
            out_data_reg.dest_occupancy <= occ_out;
            out_data_reg.error          <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // each occupied site belongs to exactly one created particle
    a_up_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_up_reg) == int'(created_up_reg))
        else $error("up occupancy disagrees with created count");

    a_dn_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_dn_reg) == int'(created_dn_reg))
        else $error("down occupancy disagrees with created count");

    // the scan only finishes while the controller waits for it
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> (state_reg == ST_SCAN))
        else $error("scan finished outside scan state");

    // a hopping particle leaves an occupied site for an empty one
    a_hop_src: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_en && is_hop) |-> (same_occ[from_reg] && !same_occ[sidx]))
        else $error("hop source empty or destination taken");
`endif

endmodule

/* tb/lattice_fermion_hop_sign_tb.sv */
// self-checking testbench for the lattice fermion hop and sign tracker
module lattice_fermion_hop_sign_tb;
    import lfhs_pkg::*;

    localparam int         LATTICE        = ADDR_SPAN;
    localparam logic [6:0] NO_OWNER       = 7'(ADDR_SPAN);
    localparam int         DRAIN_CYCLES   = 80;
    localparam int         TIMEOUT_CYCLES = 3_000_000;
    localparam int         HOLD_AFTER     = 400;
    localparam int         HOLD_CYCLES    = 500;

    // lattice occupancy tracker and result checker
    class hop_sign_scoreboard;
        logic [6:0] site_owner [2][LATTICE];
        logic [5:0] particle_home [2][LATTICE];
        int         created [2];
        int         limit_cfg [2];
        logic       sign_bit;
        out_item_t  expected_outcomes [$];
        int         mismatches;
        int         outcomes_seen;

        function new();
            for (int sp = 0; sp < 2; sp++)
            begin
                for (int s = 0; s < LATTICE; s++)
                begin
                    site_owner[sp][s]    = NO_OWNER;
                    particle_home[sp][s] = '0;
                end
                created[sp]   = 0;
                limit_cfg[sp] = 0;
            end
            sign_bit      = 1'b0;
            mismatches    = 0;
            outcomes_seen = 0;
        endfunction

        function void set_limit(int idx, logic [CFG_W-1:0] value);
            limit_cfg[idx] = int'(value);
        endfunction

        // parity of occupied sites of one species with lo <= site < hi
        function logic occupied_parity(int sp, int lo, int hi);
            logic p;
            p = 1'b0;
            for (int s = lo; s < hi; s++)
                if (site_owner[sp][s] != NO_OWNER)
                    p = ~p;
            return p;
        endfunction

        // apply one accepted transaction and queue the result it must give
        function void record_move(in_item_t mv);
            int        sp;
            int        origin;
            int        cap;
            int        pidx;
            int        dst;
            logic      flip;
            out_item_t res;
            flip      = 1'b0;
            res.error = ERR_NONE;
            sp   = (mv.mode == MODE_HOP_DOWN || mv.mode == MODE_CREATE_DOWN) ? 1 : 0;
            pidx = int'(mv.particle);
            dst  = int'(mv.site);
            if (mv.mode == MODE_HOP_UP || mv.mode == MODE_HOP_DOWN)
            begin
                if (pidx >= created[sp])
                    res.error = ERR_PARTICLE;
                else
                begin
                    origin = int'(particle_home[sp][pidx]);
                    // blocked by another same-species particle, or a hop in place
                    if ((site_owner[sp][dst] == NO_OWNER || site_owner[sp][dst] == 7'(pidx))
                        && origin != dst)
                    begin
                        if (origin < dst)
                            flip = occupied_parity(sp, origin + 1, dst);
                        else
                            flip = occupied_parity(sp, dst + 1, origin);
                        site_owner[sp][origin]  = NO_OWNER;
                        site_owner[sp][dst]     = 7'(pidx);
                        particle_home[sp][pidx] = mv.site;
                    end
                end
            end
            else
            begin
                cap = (limit_cfg[sp] > LATTICE) ? LATTICE : limit_cfg[sp];
                if (created[sp] >= cap)
                    res.error = ERR_LIMIT;
                else if (site_owner[sp][dst] == NO_OWNER)
                begin
                    // ups below always count, downs below only for a down particle
                    flip = occupied_parity(0, 0, dst);
                    if (sp == 1)
                        flip ^= occupied_parity(1, 0, dst);
                    site_owner[sp][dst]            = 7'(created[sp]);
                    particle_home[sp][created[sp]] = mv.site;
                    created[sp]++;
                end
            end
            sign_bit ^= flip;
            res.step_parity    = flip;
            res.sign_negative  = sign_bit;
            res.dest_occupancy = {site_owner[1][dst] != NO_OWNER,
                                  site_owner[0][dst] != NO_OWNER};
            expected_outcomes = {expected_outcomes, res};
        endfunction

        // compare one accepted result with the oldest queued one
        function void compare_outcome(out_item_t got);
            out_item_t want;
            outcomes_seen++;
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: parity %0b sign %0b occ %0d err %0d",
                             got.step_parity, got.sign_negative, got.dest_occupancy, got.error);
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.step_parity !== want.step_parity || got.sign_negative !== want.sign_negative
                || got.dest_occupancy !== want.dest_occupancy || got.error !== want.error)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at result %0d: expected parity %0b sign %0b occ %0d err %0d",
                             outcomes_seen, want.step_parity, want.sign_negative,
                             want.dest_occupancy, want.error);
                    $display("    got parity %0b sign %0b occ %0d err %0d",
                             got.step_parity, got.sign_negative, got.dest_occupancy, got.error);
                end
            end
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;
    logic             cfg_write = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;

    bit steady        = 1'b0;
    bit hold_done     = 1'b0;
    int moves_sent    = 0;
    int settings_used = 0;

    hop_sign_scoreboard sign_board = new();

    lattice_fermion_hop_sign uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("Regression FAIL");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sign_board.compare_outcome(out_data);
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic int stall_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(15, 120);
    endfunction

    // receiver back-pressure, with one long hold-off once results are flowing
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && sign_board.outcomes_seen >= HOLD_AFTER)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (!steady && $urandom_range(0, 99) < 30)
            begin
                out_stall <= 1'b1;
                repeat (stall_len()) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one transaction after a random gap and hold it until accepted
    task automatic offer_move(in_item_t mv);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= mv;
        do
            @(posedge clk);
        while (in_stall);
        sign_board.record_move(mv);
        moves_sent++;
    endtask

    task automatic offer_fields(mode_t m, int p, int s);
        in_item_t mv;
        mv.mode     = m;
        mv.particle = 6'(p);
        mv.site     = 6'(s);
        offer_move(mv);
    endtask

    // stop offering until every queued result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (sign_board.pending() != 0)
            @(posedge clk);
    endtask

    // write both particle limits while the block is idle
    task automatic write_limits(int up_lim, int down_lim);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_UP_LIMIT;
        cfg_data  <= CFG_W'(up_lim);
        @(posedge clk);
        sign_board.set_limit(CFG_UP_LIMIT, CFG_W'(up_lim));
        cfg_index <= CFG_DOWN_LIMIT;
        cfg_data  <= CFG_W'(down_lim);
        @(posedge clk);
        sign_board.set_limit(CFG_DOWN_LIMIT, CFG_W'(down_lim));
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // mostly hops of live particles, some hops of absent ones and creations
    function automatic in_item_t random_move(int create_pct);
        in_item_t mv;
        int       sp;
        bit       is_hop;
        mv.particle = 6'($urandom_range(0, 63));
        mv.site     = 6'($urandom_range(0, 63));
        is_hop      = ($urandom_range(0, 99) >= create_pct);
        if (is_hop)
            mv.mode = $urandom_range(0, 1) ? MODE_HOP_DOWN : MODE_HOP_UP;
        else
            mv.mode = $urandom_range(0, 1) ? MODE_CREATE_DOWN : MODE_CREATE_UP;
        sp = (mv.mode == MODE_HOP_DOWN || mv.mode == MODE_CREATE_DOWN) ? 1 : 0;
        if (is_hop && sign_board.created[sp] > 0 && $urandom_range(0, 99) < 85)
        begin
            mv.particle = 6'($urandom_range(0, sign_board.created[sp] - 1));
            if ($urandom_range(0, 9) == 0)
                mv.site = sign_board.particle_home[sp][mv.particle];
        end
        return mv;
    endfunction

    task automatic run_random(int count, int create_pct);
        for (int i = 0; i < count; i++)
            offer_move(random_move(create_pct));
    endtask

    // main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limits still zero: creations refused, hops of absent particles
        offer_fields(MODE_CREATE_UP, 0, 0);
        offer_fields(MODE_CREATE_DOWN, 63, 63);
        offer_fields(MODE_HOP_UP, 0, 5);
        offer_fields(MODE_HOP_DOWN, 63, 0);
        settle();
        write_limits(12, 10);

        // creation signs, blocked and in-place hops, double occupancy
        offer_fields(MODE_CREATE_UP, 0, 10);
        offer_fields(MODE_CREATE_UP, 0, 20);
        offer_fields(MODE_CREATE_UP, 63, 30);
        offer_fields(MODE_CREATE_DOWN, 0, 20);
        offer_fields(MODE_CREATE_DOWN, 0, 0);
        offer_fields(MODE_HOP_UP, 0, 30);
        offer_fields(MODE_HOP_UP, 0, 25);
        offer_fields(MODE_HOP_UP, 1, 20);
        offer_fields(MODE_HOP_UP, 0, 63);
        offer_fields(MODE_HOP_UP, 63, 40);
        offer_fields(MODE_HOP_DOWN, 1, 63);
        offer_fields(MODE_CREATE_UP, 0, 20);
        offer_fields(MODE_CREATE_DOWN, 0, 63);
        offer_fields(MODE_HOP_UP, 0, 0);
        offer_fields(MODE_HOP_DOWN, 0, 21);
        offer_fields(MODE_CREATE_UP, 0, 63);
        offer_fields(MODE_HOP_DOWN, 2, 42);
        settle();

        // moderate limits, with a full drain midway
        write_limits($urandom_range(12, 20), $urandom_range(8, 16));
        run_random(200, 30);
        settle();
        run_random(200, 30);
        settle();

        // limits under the created counts
        write_limits(3, 0);
        run_random(150, 40);
        settle();

        // higher limits, first stretch without any idling
        write_limits($urandom_range(28, 36), $urandom_range(24, 32));
        steady = 1'b1;
        run_random(150, 25);
        steady = 1'b0;
        run_random(300, 25);
        settle();

        // largest limits: one above the particle capacity, one at it
        write_limits(127, 64);
        run_random(530, 35);
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions over %0d limit settings, %0d results checked",
                 moves_sent, settings_used, sign_board.outcomes_seen);
        $display("lattice ended with %0d up and %0d down particles, %0d mismatches",
                 sign_board.created[0], sign_board.created[1], sign_board.mismatches);
        if (sign_board.mismatches == 0 && sign_board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
